### src/cbm_pkg.sv
`timescale 1ns / 1ps
// cbm_pkg: shared types and constants of the cartridge bank mapper
// used by cbm_decode and cartridge_bank_mapper; no dependencies

package cbm_pkg;

	localparam int MAX_ROM_BANKS_DEF = 512;
	localparam int ROM_BANK_BYTES    = 16384;
	localparam int RomOffsetBits     = $clog2(ROM_BANK_BYTES);
	localparam int RamOffsetBits     = 13;

	localparam int RomBankW   = 9;
	localparam int RamBankW   = 4;
	localparam int BankCountW = 10;
	localparam int PhysW      = 23;

	// mapper kinds
	localparam logic [1:0] KIND_MBC1 = 2'd0;
	localparam logic [1:0] KIND_MBC3 = 2'd1;
	localparam logic [1:0] KIND_MBC5 = 2'd2;

	// configuration register indexes
	localparam logic [1:0] CFG_MAPPER_KIND  = 2'd0;
	localparam logic [1:0] CFG_BANK_COUNT   = 2'd1;
	localparam logic [1:0] CFG_BOOT_PRESENT = 2'd2;

	// address pages (addr[15:12])
	localparam logic [3:0] PAGE_ROM_LO_A = 4'h2;
	localparam logic [3:0] PAGE_ROM_LO_B = 4'h3;
	localparam logic [3:0] PAGE_ROM_HI_A = 4'h4;
	localparam logic [3:0] PAGE_ROM_HI_B = 4'h5;
	localparam logic [3:0] PAGE_MODE_A   = 4'h6;
	localparam logic [3:0] PAGE_MODE_B   = 4'h7;
	localparam logic [3:0] PAGE_RAM_A    = 4'hA;
	localparam logic [3:0] PAGE_RAM_B    = 4'hB;

	localparam logic [15:0] BOOT_OFF_ADDR = 16'hFF50;
	localparam logic [7:0]  BOOT_OFF_DATA = 8'h01;

	typedef enum logic [1:0] {
		TGT_NONE = 2'd0,
		TGT_BOOT = 2'd1,
		TGT_ROM  = 2'd2,
		TGT_RAM  = 2'd3
	} target_t;

	typedef struct packed {
		logic [1:0]            kind;
		logic [BankCountW-1:0] bank_count;
		logic                  boot_present;
	} cfg_t;

	typedef struct packed {
		logic [RomBankW-1:0] rom_bank;
		logic [RamBankW-1:0] ram_bank;
		logic                mode;
		logic                boot_active;
		logic                dirty;
	} bank_state_t;

endpackage

### src/cbm_decode.sv
`timescale 1ns / 1ps
// cbm_decode: bank register update and address mapping for one bus access
// depends on cbm_pkg

module cbm_decode import cbm_pkg::*; #(
	parameter int MAX_ROM_BANKS = MAX_ROM_BANKS_DEF
) (
	input  cfg_t              cfg,
	input  bank_state_t       cur,
	input  logic              command,
	input  logic [15:0]       address,
	input  logic [7:0]        write_data,
	output bank_state_t       nxt,
	output target_t           target,
	output logic [PhysW-1:0]  physical_address
);

	localparam logic [RomBankW-1:0] MaxMask = RomBankW'(MAX_ROM_BANKS - 1);

	logic [RomBankW-1:0]   mask;
	logic [BankCountW-1:0] count_m1;
	logic [3:0]            page;
	logic                  boot_on;
	logic [RomBankW-1:0]   bank_lo;
	logic [6:0]            bank_hi;
	logic [PhysW-1:0]      ram_phys;

	assign count_m1 = cfg.bank_count - BankCountW'(1);
	assign mask     = count_m1[RomBankW-1:0] & MaxMask;
	assign page     = address[15:12];
	assign boot_on  = cur.boot_active & cfg.boot_present;
	assign ram_phys = PhysW'({cur.ram_bank, address[RamOffsetBits-1:0]});

	// bank number for a write at 0x2000-0x3fff
	always_comb begin
		case (cfg.kind)
			KIND_MBC5: begin
				if (page == PAGE_ROM_LO_A)
					bank_lo = {cur.rom_bank[8], write_data};
				else
					bank_lo = {write_data[0], cur.rom_bank[7:0]};
			end
			KIND_MBC3: begin
				bank_lo = {2'b00, write_data[6:0]};
				if (write_data[6:0] == 7'd0)
					bank_lo = 9'd1;
			end
			default: begin
				bank_lo = {2'b00, cur.rom_bank[6:5], write_data[4:0]};
				if (write_data[4:0] == 5'd0)
					bank_lo[0] = 1'b1;
			end
		endcase
	end

	// upper bits at 0x4000-0x5fff, zero and, except on MBC3, 0x20/0x40/0x60 bumped to +1
	always_comb begin
		bank_hi = {write_data[1:0], cur.rom_bank[4:0]};
		if (cfg.kind == KIND_MBC3) begin
			if (bank_hi == 7'd0)
				bank_hi = 7'd1;
		end else if (bank_hi[4:0] == 5'd0) begin
			bank_hi[0] = 1'b1;
		end
	end

	always_comb begin
		nxt              = cur;
		target           = TGT_NONE;
		physical_address = '0;
		if (command) begin
			case (page)
				PAGE_ROM_LO_A, PAGE_ROM_LO_B: begin
					nxt.rom_bank = bank_lo & mask;
				end
				PAGE_ROM_HI_A, PAGE_ROM_HI_B: begin
					if (cur.mode || cfg.kind == KIND_MBC5) begin
						if (cfg.kind == KIND_MBC5)
							nxt.ram_bank = write_data[3:0];
						else
							nxt.ram_bank = {2'b00, write_data[1:0]};
					end else begin
						nxt.rom_bank = RomBankW'(bank_hi) & mask;
					end
				end
				PAGE_MODE_A, PAGE_MODE_B: begin
					nxt.mode = write_data[0];
				end
				PAGE_RAM_A, PAGE_RAM_B: begin
					nxt.dirty        = 1'b1;
					target           = TGT_RAM;
					physical_address = ram_phys;
				end
				default: begin
					if (address == BOOT_OFF_ADDR && boot_on && write_data == BOOT_OFF_DATA)
						nxt.boot_active = 1'b0;
				end
			endcase
		end else begin
			if (address[15:14] == 2'b00) begin
				physical_address = PhysW'(address);
				if (boot_on && address[15:8] == 8'h00)
					target = TGT_BOOT;
				else
					target = TGT_ROM;
			end else if (address[15:14] == 2'b01) begin
				target           = TGT_ROM;
				physical_address = {cur.rom_bank, address[RomOffsetBits-1:0]};
			end else if (page == PAGE_RAM_A || page == PAGE_RAM_B) begin
				target           = TGT_RAM;
				physical_address = ram_phys;
			end
		end
	end

endmodule

### src/cartridge_bank_mapper.sv
`timescale 1ns / 1ps
// cartridge_bank_mapper: top level, input register, bank state and result register
// depends on cbm_pkg and cbm_decode

// Takes one bus access beat per clock unless stalled and returns one result beat per
// access through the input and result registers. The bank registers update
// as the access leaves the input register, so the following beat sees them without a
// bubble; the only loop is one decode pass over the small bank registers. A stalled
// output holds the input register and the bank state; configuration writes are taken
// in any cycle and must only be issued while no access is in flight.
module cartridge_bank_mapper import cbm_pkg::*; #(
	parameter int MAX_ROM_BANKS = MAX_ROM_BANKS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [23:0]           s_tdata,   // address[15:0], write_data[23:16]
	input  logic                  s_tuser,   // command[0]
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [39:0]           m_tdata,   // physical_address[22:0], current_rom_bank[31:23],
	                                         // current_ram_bank[35:32], mode_now[36],
	                                         // ram_dirty[37], zero[39:38]
	output logic [1:0]            m_tuser,   // target[1:0]
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [1:0]            cfg_index,
	input  logic [BankCountW-1:0] cfg_data
);

	cfg_t        cfg_q;
	bank_state_t state_q;
	bank_state_t state_nxt;

	logic        valid_s1;
	logic        cmd_s1;
	logic [15:0] addr_s1;
	logic [7:0]  data_s1;
	logic        advance;

	target_t          tgt;
	logic [PhysW-1:0] phys;

	logic             out_valid_q;
	target_t          tgt_q;
	logic [PhysW-1:0] phys_q;
	bank_state_t      res_q;

	assign advance   = !out_valid_q || m_tready;
	assign s_tready  = !valid_s1 || advance;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.kind         <= KIND_MBC1;
			cfg_q.bank_count   <= BankCountW'(2);
			cfg_q.boot_present <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_MAPPER_KIND:  cfg_q.kind         <= cfg_data[1:0];
				CFG_BANK_COUNT:   cfg_q.bank_count   <= cfg_data;
				CFG_BOOT_PRESENT: cfg_q.boot_present <= cfg_data[0];
				default:          cfg_q <= cfg_q;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cmd_s1  <= s_tuser;
			addr_s1 <= s_tdata[15:0];
			data_s1 <= s_tdata[23:16];
		end
	end

	cbm_decode #(
		.MAX_ROM_BANKS(MAX_ROM_BANKS)
	) u_decode (
		.cfg              (cfg_q),
		.cur              (state_q),
		.command          (cmd_s1),
		.address          (addr_s1),
		.write_data       (data_s1),
		.nxt              (state_nxt),
		.target           (tgt),
		.physical_address (phys)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.rom_bank    <= RomBankW'(1);
			state_q.ram_bank    <= '0;
			state_q.mode        <= 1'b0;
			state_q.boot_active <= 1'b1;
			state_q.dirty       <= 1'b0;
			out_valid_q         <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
			if (valid_s1)
				state_q <= state_nxt;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			tgt_q  <= tgt;
			phys_q <= phys;
			res_q  <= state_nxt;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = tgt_q;
	assign m_tdata  = {2'b00, res_q.dirty, res_q.mode, res_q.ram_bank, res_q.rom_bank, phys_q};

`ifndef NO_ASSERTIONS
	a_none_zero_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && tgt_q == TGT_NONE) |-> (phys_q == '0))
		else $error("unmapped beat carries a nonzero address");

	a_dirty_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		!$fell(state_q.dirty))
		else $error("ram dirty mark cleared");

	a_boot_no_return: assert property (@(posedge clk) disable iff (!arst_n)
		!$rose(state_q.boot_active))
		else $error("boot overlay came back");

	a_stall_holds_state: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> $stable(state_q))
		else $error("bank state changed while output stalled");

	a_boot_needs_overlay: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && tgt_q == TGT_BOOT) |-> (phys_q[PhysW-1:8] == '0))
		else $error("boot rom beat outside the overlay");
`endif

endmodule

### tb/cbm_checker.sv
`timescale 1ns / 1ps
// cbm_checker: watches the access, result and register channels of cartridge_bank_mapper,
// predicts each result beat from its own bank state and compares it field by field
// depends on cbm_pkg

module cbm_checker import cbm_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	input  logic                  s_tready,
	input  logic [23:0]           s_tdata,   // address[15:0], write_data[23:16]
	input  logic                  s_tuser,   // command[0]
	input  logic                  m_tvalid,
	input  logic                  m_tready,
	input  logic [39:0]           m_tdata,   // physical_address[22:0], current_rom_bank[31:23],
	                                         // current_ram_bank[35:32], mode_now[36],
	                                         // ram_dirty[37], zero[39:38]
	input  logic [1:0]            m_tuser,   // target[1:0]
	input  logic                  cfg_valid,
	input  logic                  cfg_ready,
	input  logic [1:0]            cfg_index,
	input  logic [BankCountW-1:0] cfg_data,
	output int                    errors,
	output int                    pending
);

	typedef struct packed {
		target_t             target;
		logic [PhysW-1:0]    phys;
		logic [RomBankW-1:0] rom_bank;
		logic [RamBankW-1:0] ram_bank;
		logic                mode;
		logic                dirty;
	} access_result_t;

	bank_state_t    bank;
	cfg_t           cfg;
	access_result_t result_q[$];

	function automatic logic [RomBankW-1:0] masked_bank(input logic [RomBankW-1:0] v);
		logic [BankCountW-1:0] count_m1;
		count_m1 = cfg.bank_count - BankCountW'(1);
		return v & count_m1[RomBankW-1:0] & RomBankW'(MAX_ROM_BANKS_DEF - 1);
	endfunction

	function automatic logic is_skip(input logic [RomBankW-1:0] v);
		return v == 9'h000 || v == 9'h020 || v == 9'h040 || v == 9'h060;
	endfunction

	function automatic access_result_t map_access(input logic wr, input logic [15:0] addr,
		input logic [7:0] data);
		access_result_t r;
		logic [RomBankW-1:0] v;
		logic [3:0] page;
		logic boot_on;
		r = '0;
		r.target = TGT_NONE;
		v = '0;
		page = addr[15:12];
		boot_on = bank.boot_active && cfg.boot_present;
		if (wr) begin
			case (page)
				PAGE_ROM_LO_A, PAGE_ROM_LO_B: begin
					if (cfg.kind == KIND_MBC5) begin
						if (page == PAGE_ROM_LO_A)
							v = {bank.rom_bank[8], data};
						else
							v = {data[0], bank.rom_bank[7:0]};
					end else if (cfg.kind == KIND_MBC3) begin
						v = {2'b00, data[6:0]};
						if (v == '0)
							v = 9'd1;
					end else begin
						v = {4'b0000, data[4:0]};
						if (is_skip(v))
							v = v + 9'd1;
						v = v | (bank.rom_bank & 9'h060);
					end
					bank.rom_bank = masked_bank(v);
				end
				PAGE_ROM_HI_A, PAGE_ROM_HI_B: begin
					if (bank.mode || cfg.kind == KIND_MBC5) begin
						bank.ram_bank = (cfg.kind == KIND_MBC5) ? data[3:0] : {2'b00, data[1:0]};
					end else begin
						v = {2'b00, data[1:0], bank.rom_bank[4:0]};
						if (cfg.kind == KIND_MBC3) begin
							if (v == '0)
								v = 9'd1;
						end else if (is_skip(v)) begin
							v = v + 9'd1;
						end
						bank.rom_bank = masked_bank(v);
					end
				end
				PAGE_MODE_A, PAGE_MODE_B: bank.mode = data[0];
				PAGE_RAM_A, PAGE_RAM_B: begin
					bank.dirty = 1'b1;
					r.target = TGT_RAM;
					r.phys = {6'd0, bank.ram_bank, addr[12:0]};
				end
				default: begin
					if (addr == BOOT_OFF_ADDR && boot_on && data == BOOT_OFF_DATA)
						bank.boot_active = 1'b0;
				end
			endcase
		end else begin
			if (addr < 16'h4000) begin
				r.target = (boot_on && addr < 16'h0100) ? TGT_BOOT : TGT_ROM;
				r.phys = PhysW'(addr);
			end else if (addr < 16'h8000) begin
				r.target = TGT_ROM;
				r.phys = {bank.rom_bank, addr[13:0]};
			end else if (page == PAGE_RAM_A || page == PAGE_RAM_B) begin
				r.target = TGT_RAM;
				r.phys = {6'd0, bank.ram_bank, addr[12:0]};
			end
		end
		r.rom_bank = bank.rom_bank;
		r.ram_bank = bank.ram_bank;
		r.mode = bank.mode;
		r.dirty = bank.dirty;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		access_result_t want;
		access_result_t got;
		if (!arst_n) begin
			bank = '{rom_bank: 9'd1, ram_bank: 4'd0, mode: 1'b0, boot_active: 1'b1, dirty: 1'b0};
			cfg = '{kind: KIND_MBC1, bank_count: 10'd2, boot_present: 1'b0};
			result_q.delete();
			errors = 0;
			pending = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got.target = target_t'(m_tuser);
				got.phys = m_tdata[22:0];
				got.rom_bank = m_tdata[31:23];
				got.ram_bank = m_tdata[35:32];
				got.mode = m_tdata[36];
				got.dirty = m_tdata[37];
				if (result_q.size() == 0) begin
					if (errors < 10)
						$display("%0t: result beat with no access pending", $realtime);
					errors++;
				end else begin
					want = result_q.pop_front();
					if (got.target !== want.target || got.phys !== want.phys ||
						got.rom_bank !== want.rom_bank || got.ram_bank !== want.ram_bank ||
						got.mode !== want.mode || got.dirty !== want.dirty) begin
						if (errors < 10) begin
							$display("%0t: mismatch exp tgt=%0d phys=%h rom=%h ram=%h mode=%b dirty=%b",
								$realtime, want.target, want.phys, want.rom_bank,
								want.ram_bank, want.mode, want.dirty);
							$display("%0t: mismatch got tgt=%0d phys=%h rom=%h ram=%h mode=%b dirty=%b",
								$realtime, got.target, got.phys, got.rom_bank,
								got.ram_bank, got.mode, got.dirty);
						end
						errors++;
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_MAPPER_KIND:  cfg.kind = cfg_data[1:0];
					CFG_BANK_COUNT:   cfg.bank_count = cfg_data;
					CFG_BOOT_PRESENT: cfg.boot_present = cfg_data[0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				result_q.push_back(map_access(s_tuser, s_tdata[15:0], s_tdata[23:16]));
			pending = result_q.size();
		end
	end

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// tb: stimulus and verdict for cartridge_bank_mapper, directed accesses then random
// bank-switching traffic over several mapper settings; depends on cbm_pkg and cbm_checker

module tb;
	import cbm_pkg::*;

	localparam int ClkPeriod   = 12;
	localparam int PhaseCount  = 10;
	localparam int PhaseItems  = 175;

	// unused mapper kind and unused register index
	localparam logic [1:0] KIND_SPARE = 2'd3;
	localparam logic [1:0] CFG_SPARE  = 2'd3;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [23:0]           s_tdata;   // address[15:0], write_data[23:16]
	logic                  s_tuser;   // command[0]
	logic                  m_tvalid;
	logic                  m_tready;
	logic [39:0]           m_tdata;   // physical_address[22:0], current_rom_bank[31:23],
	                                  // current_ram_bank[35:32], mode_now[36],
	                                  // ram_dirty[37], zero[39:38]
	logic [1:0]            m_tuser;   // target[1:0]
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [1:0]            cfg_index;
	logic [BankCountW-1:0] cfg_data;
	int                    errors;
	int                    pending;
	bit                    steady;

	cartridge_bank_mapper u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	cbm_checker u_chk (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.errors(errors), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #(ClkPeriod / 2) clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("TEST FAILED");
		$finish;
	end

	always @(negedge clk) begin
		if (!arst_n)
			m_tready <= 1'b0;
		else
			m_tready <= steady || ($urandom_range(0, 99) >= 28);
	end

	task automatic send(input logic cmd, input logic [15:0] addr, input logic [7:0] data);
		while (!steady && $urandom_range(0, 99) < 28) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {data, addr};
		s_tuser <= cmd;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// drop valid and let every outstanding access come back
	task automatic settle();
		s_tvalid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (3) @(negedge clk);
	endtask

	task automatic set_reg(input logic [1:0] idx, input logic [BankCountW-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	// upper data bits are don't-care for the narrow registers
	task automatic configure(input logic [1:0] kind, input logic [BankCountW-1:0] count,
		input logic boot);
		set_reg(CFG_MAPPER_KIND, {8'($urandom), kind});
		set_reg(CFG_BANK_COUNT, count);
		set_reg(CFG_BOOT_PRESENT, {9'($urandom), boot});
	endtask

	task automatic send_random();
		int pick;
		logic [7:0] d;
		logic [12:0] off;
		pick = $urandom_range(0, 99);
		d = 8'($urandom);
		off = 13'($urandom);
		if (pick < 15)
			send(1'b1, {3'b001, off}, d);
		else if (pick < 25)
			send(1'b1, {3'b010, off}, d);
		else if (pick < 33)
			send(1'b1, {3'b011, off}, d);
		else if (pick < 53)
			send(1'b0, 16'($urandom_range(16'h4000, 16'h7FFF)), d);
		else if (pick < 63)
			send(1'b0, $urandom_range(0, 1) ? 16'($urandom_range(0, 255))
				: 16'($urandom_range(0, 16'h3FFF)), d);
		else if (pick < 73)
			send(1'b0, 16'($urandom_range(16'hA000, 16'hBFFF)), d);
		else if (pick < 81)
			send(1'b1, 16'($urandom_range(16'hA000, 16'hBFFF)), d);
		else if (pick < 83)
			send(1'b1, BOOT_OFF_ADDR, $urandom_range(0, 1) ? BOOT_OFF_DATA : d);
		else if (pick < 90)
			send(1'($urandom), 16'($urandom), d);
		else if ($urandom_range(0, 1))
			send(1'b1, 16'($urandom_range(0, 16'h1FFF)), d);
		else
			send(1'($urandom), 16'($urandom_range(16'h8000, 16'hFFFF)), d);
	endtask

	initial begin
		int wait_cnt;
		arst_n = 1'b0;
		steady = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = CFG_MAPPER_KIND;
		cfg_data = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset settings, overlay not in effect so the end-of-boot write is ignored
		send(1'b0, 16'h0000, 8'h00);
		send(1'b1, BOOT_OFF_ADDR, BOOT_OFF_DATA);
		settle();
		set_reg(CFG_SPARE, 10'h3FF);
		configure(KIND_MBC1, 10'd512, 1'b1);
		send(1'b0, 16'h0000, 8'h00);
		send(1'b0, 16'h00FF, 8'hFF);
		send(1'b0, 16'h0100, 8'h00);
		send(1'b1, BOOT_OFF_ADDR, 8'h00);
		send(1'b1, BOOT_OFF_ADDR, 8'h03);
		send(1'b0, 16'h0000, 8'h00);
		send(1'b1, 16'h2000, 8'h00);
		send(1'b1, 16'h3FFF, 8'hFF);
		send(1'b1, 16'h4000, 8'h01);
		send(1'b1, 16'h2000, 8'h00);
		send(1'b0, 16'h7FFF, 8'h00);
		send(1'b1, 16'h6000, 8'h01);
		send(1'b1, 16'h5FFF, 8'hFF);
		send(1'b1, 16'hA000, 8'hAA);
		send(1'b0, 16'hBFFF, 8'h00);
		send(1'b0, 16'hC000, 8'h00);
		send(1'b0, 16'h8000, 8'h00);
		send(1'b1, BOOT_OFF_ADDR, BOOT_OFF_DATA);
		send(1'b0, 16'h0000, 8'h00);
		send(1'b1, 16'hFFFF, 8'hFF);
		send(1'b1, 16'h1000, 8'h00);
		settle();
		configure(KIND_MBC5, 10'd512, 1'b0);
		send(1'b1, 16'h2000, 8'hFF);
		send(1'b1, 16'h3000, 8'h01);
		send(1'b0, 16'h4000, 8'h00);
		send(1'b1, 16'h2000, 8'h00);
		send(1'b0, 16'h7FFF, 8'h00);
		settle();

		for (int ph = 0; ph < PhaseCount; ph++) begin
			case (ph)
				0: configure(KIND_MBC1, 10'd512, 1'b1);
				1: configure(KIND_MBC3, 10'd128, 1'b0);
				2: configure(KIND_MBC5, 10'd0, 1'b1);
				3: configure(KIND_SPARE, 10'd64, 1'b0);
				4: configure(KIND_MBC1, 10'd1, 1'b0);
				5: configure(KIND_MBC5, 10'd3, 1'b1);
				6: configure(KIND_MBC3, 10'd1023, 1'b1);
				7: configure(KIND_MBC1, 10'd2, 1'b0);
				default: configure(2'($urandom), $urandom_range(0, 3) == 0 ? 10'($urandom)
					: 10'(1 << $urandom_range(0, 9)), 1'($urandom));
			endcase
			steady = (ph == 2);
			for (int i = 0; i < PhaseItems; i++) begin
				if (ph == 4 && i == PhaseItems / 2)
					settle();
				send_random();
			end
			settle();
		end
		steady = 1'b0;

		s_tvalid <= 1'b0;
		wait_cnt = 0;
		while (pending != 0 && wait_cnt < 5000) begin
			@(negedge clk);
			wait_cnt++;
		end
		repeat (10) @(negedge clk);
		if (errors == 0 && pending == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
